@@ rtl/prrt_pkg.sv @@
package prrt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned PORT_SPACE  = 65536;

  localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned START_W = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned OWNER_W = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SUM_W   = COUNT_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_FREE_OWNER = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_DENIED  = 3'd2,
    ST_BUSY    = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] length;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } tbl_req_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } tbl_rsp_t;

endpackage

@@ rtl/prrt_if.sv @@
interface prrt_req_if;
  logic                         valid;
  logic                         ready;
  logic [prrt_pkg::OP_W-1:0]    operation;
  logic [prrt_pkg::START_W-1:0] range_start;
  logic [prrt_pkg::COUNT_W-1:0] range_count;
  logic [prrt_pkg::OWNER_W-1:0] owner_id;
  logic                         caller_is_server;

  modport source (
    output valid, operation, range_start, range_count, owner_id, caller_is_server,
    input  ready
  );
  modport sink (
    input  valid, operation, range_start, range_count, owner_id, caller_is_server,
    output ready
  );
endinterface

interface prrt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [prrt_pkg::STAT_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

@@ rtl/prrt_table.sv @@
module prrt_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prrt_pkg::tbl_req_t req_i,
  output prrt_pkg::tbl_rsp_t rsp_o
);
  import prrt_pkg::*;

  entry_t                 mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  entry_t                 rd_entry_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.rd_addr];
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end else if (req_i.clr_en) begin
        valid_q[req_i.clr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_entry_q <= mem_q[req_i.rd_addr];
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  assign rsp_o.valid = rd_valid_q;
  assign rsp_o.entry = rd_entry_q;

endmodule

@@ rtl/port_range_reservation_table.sv @@
// Reservation table for I/O port ranges, 16 slots. One operation at a time:
// register, unregister by start port, or free every slot of an owner; each
// returns one status beat. A request is taken only when the block is idle.
// A request that scans the whole table passes a decode state, then the
// scan: 16 slots go through a single read port and one shared
// overlap/match compare, one slot per cycle, behind the registered table
// read. Then the status register is loaded and the block returns to idle.
// A register that stores a range adds a write-back state. Rejected
// arguments and the undefined operation skip the scan. A scan stops
// at the first overlap or at the first unregister match.
// A new request is accepted while the previous status still waits. If a
// second status is ready before the first beat leaves, the block stalls
// until it does.
module port_range_reservation_table (
  input logic      clk_i,
  input logic      rst_ni,
  prrt_req_if.sink req_i,
  prrt_rsp_if.source rsp_o
);
  import prrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

  localparam logic [IDX_W-1:0] LastIdx   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [SUM_W-1:0] PortSpace = SUM_W'(PORT_SPACE);

  state_e             state_q;
  logic [OP_W-1:0]    op_q;
  logic [START_W-1:0] start_q;
  logic [COUNT_W-1:0] count_q;
  logic [OWNER_W-1:0] owner_q;
  logic               server_q;
  logic [IDX_W-1:0]   idx_q;
  logic               issue_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  status_e            status_q;
  logic               out_vld_q;
  logic [STAT_W-1:0]  out_status_q;

  tbl_req_t           tbl_req;
  tbl_rsp_t           tbl_rsp;

  logic [SUM_W-1:0]   req_end;
  logic [SUM_W-1:0]   ent_end;
  logic               overlap;
  logic               start_hit;
  logic               owner_hit;
  logic               cmp_last;

  prrt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  assign req_end   = SUM_W'(start_q) + SUM_W'(count_q);
  assign ent_end   = SUM_W'(tbl_rsp.entry.start) + SUM_W'(tbl_rsp.entry.length);
  assign overlap   = (SUM_W'(start_q) < ent_end) && (SUM_W'(tbl_rsp.entry.start) < req_end);
  assign start_hit = (tbl_rsp.entry.start == start_q);
  assign owner_hit = (tbl_rsp.entry.owner == owner_q);
  assign cmp_last  = (cmp_idx_q == LastIdx);

  always_comb begin
    tbl_req               = '0;
    tbl_req.rd_addr       = idx_q;
    tbl_req.wr_addr       = free_idx_q;
    tbl_req.wr_data.start = start_q;
    tbl_req.wr_data.length = count_q;
    tbl_req.wr_data.owner = owner_q;
    tbl_req.clr_addr      = cmp_idx_q;
    tbl_req.wr_en         = (state_q == S_WRITE);
    if (state_q == S_SCAN && cmp_vld_q && tbl_rsp.valid) begin
      unique case (op_q)
        OP_UNREGISTER: tbl_req.clr_en = start_hit;
        OP_FREE_OWNER: tbl_req.clr_en = owner_hit;
        default:       tbl_req.clr_en = 1'b0;
      endcase
    end
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      start_q      <= '0;
      count_q      <= '0;
      owner_q      <= '0;
      server_q     <= 1'b0;
      idx_q        <= '0;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      status_q     <= ST_OK;
      out_vld_q    <= 1'b0;
      out_status_q <= '0;
    end else begin
      if (out_vld_q && rsp_o.ready && state_q != S_RESP) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q     <= req_i.operation;
            start_q  <= req_i.range_start;
            count_q  <= req_i.range_count;
            owner_q  <= req_i.owner_id;
            server_q <= req_i.caller_is_server;
            state_q  <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx_q        <= '0;
          issue_q      <= 1'b1;
          cmp_vld_q    <= 1'b0;
          free_found_q <= 1'b0;
          unique case (op_q)
            OP_REGISTER: begin
              if (count_q == '0 || req_end > PortSpace) begin
                status_q <= ST_INVALID;
                state_q  <= S_RESP;
              end else if (!server_q) begin
                status_q <= ST_DENIED;
                state_q  <= S_RESP;
              end else begin
                state_q  <= S_SCAN;
              end
            end
            OP_UNREGISTER, OP_FREE_OWNER: state_q <= S_SCAN;
            default: begin
              status_q <= ST_INVALID;
              state_q  <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          cmp_vld_q <= issue_q;
          cmp_idx_q <= idx_q;
          if (issue_q) begin
            if (idx_q == LastIdx) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
          if (cmp_vld_q) begin
            unique case (op_q)
              OP_REGISTER: begin
                if (tbl_rsp.valid && overlap) begin
                  status_q <= ST_BUSY;
                  state_q  <= S_RESP;
                end else begin
                  if (!tbl_rsp.valid && !free_found_q) begin
                    free_found_q <= 1'b1;
                    free_idx_q   <= cmp_idx_q;
                  end
                  if (cmp_last) begin
                    if (free_found_q || !tbl_rsp.valid) begin
                      state_q <= S_WRITE;
                    end else begin
                      status_q <= ST_FULL;
                      state_q  <= S_RESP;
                    end
                  end
                end
              end
              OP_UNREGISTER: begin
                if (tbl_rsp.valid && start_hit) begin
                  status_q <= ST_OK;
                  state_q  <= S_RESP;
                end else if (cmp_last) begin
                  status_q <= ST_INVALID;
                  state_q  <= S_RESP;
                end
              end
              default: begin
                if (cmp_last) begin
                  status_q <= ST_OK;
                  state_q  <= S_RESP;
                end
              end
            endcase
          end
        end
        S_WRITE: begin
          status_q <= ST_OK;
          state_q  <= S_RESP;
        end
        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q    <= 1'b1;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
